// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, quiet while reset is active.
`define AST_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Condition that must hold at every clock edge out of reset.
`define AST_ALWAYS(lbl, clk, rst_n, cond) \
	`AST_PROP(lbl, clk, rst_n, cond)

`endif

// ----- rtl/core/iegu_pkg.sv -----
`timescale 1ns / 1ps

package iegu_pkg;

	// item selector codes
	localparam logic [2:0] FN_RAW   = 3'd0;
	localparam logic [2:0] FN_KEY   = 3'd1;
	localparam logic [2:0] FN_MOUSE = 3'd2;
	localparam logic [2:0] FN_BUF   = 3'd3;
	localparam logic [2:0] FN_RESET = 3'd4;

	// event slots within one item
	localparam logic [2:0] SL_FIRST = 3'd0;
	localparam logic [2:0] SL_Y     = 3'd1;
	localparam logic [2:0] SL_BTN0  = 3'd2;
	localparam logic [2:0] SL_BTN1  = 3'd3;
	localparam logic [2:0] SL_BTN2  = 3'd4;
	localparam logic [2:0] SL_SYNC  = 3'd5;

	// button masks
	localparam logic [2:0] BTN0_MASK = 3'h1;
	localparam logic [2:0] BTN1_MASK = 3'h2;
	localparam logic [2:0] BTN2_MASK = 3'h4;

	// event types and codes
	localparam logic [15:0] EV_SYN   = 16'h0000;
	localparam logic [15:0] EV_KEY   = 16'h0001;
	localparam logic [15:0] EV_REL   = 16'h0002;
	localparam logic [15:0] REL_X    = 16'h0000;
	localparam logic [15:0] REL_Y    = 16'h0001;
	localparam logic [15:0] BTN_L_CD = 16'h0110;
	localparam logic [15:0] BTN_R_CD = 16'h0111;
	localparam logic [15:0] BTN_M_CD = 16'h0112;

	localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [15:0] ev_type;
		logic [15:0] ev_code;
		logic [31:0] ev_value;
	} event_t;

	typedef struct packed {
		logic   en;
		event_t ev;
	} slot_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] x);
		return (x == SAT_MAX) ? x : x + 32'd1;
	endfunction

endpackage

// ----- rtl/core/input_event_queue_to_guest_unit.sv -----
// Steps: raw item S_EVT for one slot, then S_FIN; key/mouse item S_EVT for six slots, then S_FIN;
// buffer item S_BUF, then S_RD when a queued event is read out, then S_FIN; reset/unused S_FIN.
// One item at a time: busy drops as the last strobe rises. Key and mouse items walk six event
// slots, each writing at most one ring entry.
// Reset (arst_n low) empties ring and credits and clears both counters; no clearing pass.
// Results cannot be stalled: every result shows for exactly one cycle on strobe.
`timescale 1ns / 1ps

module input_event_queue_to_guest_unit #(
	parameter int EVENT_DEPTH        = 64,
	parameter int GUEST_BUFFER_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// command side
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [15:0] event_type,
	input  logic [15:0] event_code,
	input  logic [31:0] event_value,
	input  logic        pressed,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic [2:0]  buttons,
	input  logic        buffer_present,
	input  logic        buffer_writable,
	input  logic [31:0] buffer_length,
	// result side
	output logic        strobe,
	output logic        delivered,
	output logic [15:0] out_type,
	output logic [15:0] out_code,
	output logic [31:0] out_value,
	output logic        interrupt,
	output logic        accepted,
	output logic [31:0] dropped_total,
	output logic [31:0] sent_total,
	output logic [$clog2(EVENT_DEPTH+1)-1:0] queued_count,
	output logic        last
);
	import iegu_pkg::*;
	`include "assert_macros.svh"

	localparam int AW = $clog2(EVENT_DEPTH);
	localparam int FW = $clog2(EVENT_DEPTH + 1);
	localparam int CW = $clog2(GUEST_BUFFER_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVT  = 3'd1; // one event slot per cycle
	localparam logic [2:0] S_BUF  = 3'd2; // credit check, ring read issue
	localparam logic [2:0] S_RD   = 3'd3; // ring read data back
	localparam logic [2:0] S_FIN  = 3'd4; // final result

	logic [2:0] state_q;

	// latched item
	logic [2:0]  func_q;
	logic [15:0] etype_q, ecode_q;
	logic [31:0] evalue_q, dx_q, dy_q, blen_q;
	logic        press_q, present_q, writable_q;
	logic [2:0]  btn_q;
	logic [2:0]  slot_q;
	logic        acc_q;

	// ring and credit bookkeeping
	logic [AW-1:0] rp_q, wp_q;
	logic [FW-1:0] fill_q;
	logic [CW-1:0] credits_q;
	logic [31:0]   drop_q, sent_q;

	// event memory, synchronous read into rd_data
	event_t        mem [EVENT_DEPTH];
	event_t        rd_data;
	logic          wr_en, rd_en;
	event_t        wr_data;

	// delivery waiting to learn whether it is the last of the item
	logic          pend_q;
	event_t        pend_ev_q;
	logic [31:0]   pend_drop_q, pend_sent_q;
	logic [FW-1:0] pend_fill_q;

	// result registers
	logic          strobe_q, dlv_q, acc_out_q, last_q;
	event_t        out_ev_q;
	logic [31:0]   out_drop_q, out_sent_q;
	logic [FW-1:0] out_fill_q;

	slot_t slot_ev;

	iegu_slot_gen u_slot (
		.func        (func_q),
		.slot        (slot_q),
		.event_type  (etype_q),
		.event_code  (ecode_q),
		.event_value (evalue_q),
		.pressed     (press_q),
		.delta_x     (dx_q),
		.delta_y     (dy_q),
		.buttons     (btn_q),
		.slot_ev     (slot_ev)
	);

	logic          ring_full, has_credit, usable, credit_room;
	logic [2:0]    last_slot;
	logic [AW-1:0] wp_nxt, rp_nxt;

	assign ring_full   = (fill_q == FW'(EVENT_DEPTH));
	assign has_credit  = (credits_q != '0);
	assign credit_room = (credits_q != CW'(GUEST_BUFFER_DEPTH));
	assign usable      = present_q && writable_q && (blen_q[31:3] != 29'd0);
	assign last_slot   = (func_q == FN_RAW) ? SL_FIRST : SL_SYNC;
	assign wp_nxt      = (wp_q == AW'(EVENT_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_nxt      = (rp_q == AW'(EVENT_DEPTH - 1)) ? '0 : rp_q + 1'b1;

	// Ring and credits are never both nonempty between events: a held credit
	// means the ring is empty, so a pushed event goes straight to the guest.
	assign wr_en   = (state_q == S_EVT) && slot_ev.en && !ring_full;
	assign wr_data = slot_ev.ev;
	assign rd_en   = (state_q == S_BUF) && usable && credit_room && (fill_q != '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rp_q];
		end
	end

	// payload latch
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_q     <= func;
			etype_q    <= event_type;
			ecode_q    <= event_code;
			evalue_q   <= event_value;
			press_q    <= pressed;
			dx_q       <= delta_x;
			dy_q       <= delta_y;
			btn_q      <= buttons;
			present_q  <= buffer_present;
			writable_q <= buffer_writable;
			blen_q     <= buffer_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= SL_FIRST;
			acc_q       <= 1'b0;
			rp_q        <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			credits_q   <= '0;
			drop_q      <= '0;
			sent_q      <= '0;
			pend_q      <= 1'b0;
			pend_ev_q   <= '0;
			pend_drop_q <= '0;
			pend_sent_q <= '0;
			pend_fill_q <= '0;
			strobe_q    <= 1'b0;
			dlv_q       <= 1'b0;
			acc_out_q   <= 1'b0;
			last_q      <= 1'b0;
			out_ev_q    <= '0;
			out_drop_q  <= '0;
			out_sent_q  <= '0;
			out_fill_q  <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						slot_q <= SL_FIRST;
						acc_q  <= 1'b1;
						pend_q <= 1'b0;
						case (func)
							FN_RAW, FN_KEY, FN_MOUSE: state_q <= S_EVT;
							FN_BUF: state_q <= S_BUF;
							FN_RESET: begin
								rp_q      <= '0;
								wp_q      <= '0;
								fill_q    <= '0;
								credits_q <= '0;
								state_q   <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_EVT: begin
					if (slot_ev.en) begin
						if (ring_full) begin
							drop_q <= sat_inc(drop_q);
							acc_q  <= 1'b0;
						end else begin
							wp_q <= wp_nxt;
							if (has_credit) begin
								// straight delivery; ring stays empty
								rp_q        <= rp_nxt;
								credits_q   <= credits_q - 1'b1;
								sent_q      <= sat_inc(sent_q);
								pend_q      <= 1'b1;
								pend_ev_q   <= slot_ev.ev;
								pend_drop_q <= drop_q;
								pend_sent_q <= sat_inc(sent_q);
								pend_fill_q <= fill_q;
								if (pend_q) begin
									// earlier delivery is not the last one
									strobe_q   <= 1'b1;
									dlv_q      <= 1'b1;
									out_ev_q   <= pend_ev_q;
									out_drop_q <= pend_drop_q;
									out_sent_q <= pend_sent_q;
									out_fill_q <= pend_fill_q;
									acc_out_q  <= 1'b0;
									last_q     <= 1'b0;
								end
							end else begin
								fill_q <= fill_q + 1'b1;
							end
						end
					end
					if (slot_q == last_slot) begin
						state_q <= S_FIN;
					end else begin
						slot_q <= slot_q + 3'd1;
					end
				end
				S_BUF: begin
					if (usable && credit_room) begin
						if (fill_q != '0) begin
							state_q <= S_RD;
						end else begin
							credits_q <= credits_q + 1'b1;
							state_q   <= S_FIN;
						end
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RD: begin
					// the new credit is spent on the oldest ring entry
					rp_q      <= rp_nxt;
					fill_q    <= fill_q - 1'b1;
					sent_q    <= sat_inc(sent_q);
					pend_q    <= 1'b1;
					pend_ev_q <= rd_data;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					strobe_q   <= 1'b1;
					dlv_q      <= pend_q;
					out_ev_q   <= pend_q ? pend_ev_q : '0;
					out_drop_q <= drop_q;
					out_sent_q <= sent_q;
					out_fill_q <= fill_q;
					acc_out_q  <= acc_q && (func_q inside {FN_RAW, FN_KEY});
					last_q     <= 1'b1;
					pend_q     <= 1'b0;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign strobe        = strobe_q;
	assign delivered     = dlv_q;
	assign interrupt     = dlv_q;
	assign out_type      = out_ev_q.ev_type;
	assign out_code      = out_ev_q.ev_code;
	assign out_value     = out_ev_q.ev_value;
	assign accepted      = acc_out_q;
	assign dropped_total = out_drop_q;
	assign sent_total    = out_sent_q;
	assign queued_count  = out_fill_q;
	assign last          = last_q;

	// events and credits never wait together between items
	`AST_ALWAYS(a_no_idle_pair, clk, arst_n, state_q != S_IDLE || fill_q == '0 || credits_q == '0)
	// bookkeeping stays in range
	`AST_ALWAYS(a_fill_range, clk, arst_n, fill_q <= FW'(EVENT_DEPTH))
	`AST_ALWAYS(a_credit_range, clk, arst_n, credits_q <= CW'(GUEST_BUFFER_DEPTH))
	// an accepted item keeps the block busy
	`AST_PROP(a_start_busy, clk, arst_n, start && !busy |=> busy)
	// a delivery always shows a nonzero send count
	`AST_ALWAYS(a_dlv_count, clk, arst_n, !(strobe && delivered) || sent_total != 32'd0)

endmodule

// ----- rtl/core/iegu_slot_gen.sv -----
`timescale 1ns / 1ps

// Decodes which event, if any, a slot of the current item queues.
module iegu_slot_gen (
	input  logic [2:0]   func,
	input  logic [2:0]   slot,
	input  logic [15:0]  event_type,
	input  logic [15:0]  event_code,
	input  logic [31:0]  event_value,
	input  logic         pressed,
	input  logic [31:0]  delta_x,
	input  logic [31:0]  delta_y,
	input  logic [2:0]   buttons,
	output iegu_pkg::slot_t slot_ev
);
	import iegu_pkg::*;

	always_comb begin
		slot_ev = '0;
		case (func)
			FN_RAW: begin
				slot_ev.en = (slot == SL_FIRST);
				slot_ev.ev = '{event_type, event_code, event_value};
			end
			FN_KEY: begin
				if (slot == SL_FIRST) begin
					slot_ev.en = 1'b1;
					slot_ev.ev = '{EV_KEY, event_code, {31'd0, pressed}};
				end else if (slot == SL_SYNC) begin
					slot_ev.en = 1'b1;
					slot_ev.ev = '{EV_SYN, 16'd0, 32'd0};
				end
			end
			FN_MOUSE: begin
				case (slot)
					SL_FIRST: begin
						slot_ev.en = (delta_x != 32'd0);
						slot_ev.ev = '{EV_REL, REL_X, delta_x};
					end
					SL_Y: begin
						slot_ev.en = (delta_y != 32'd0);
						slot_ev.ev = '{EV_REL, REL_Y, delta_y};
					end
					SL_BTN0: begin
						slot_ev.en = |(buttons & BTN0_MASK);
						slot_ev.ev = '{EV_KEY, BTN_L_CD, 32'd1};
					end
					SL_BTN1: begin
						slot_ev.en = |(buttons & BTN1_MASK);
						slot_ev.ev = '{EV_KEY, BTN_R_CD, 32'd1};
					end
					SL_BTN2: begin
						slot_ev.en = |(buttons & BTN2_MASK);
						slot_ev.ev = '{EV_KEY, BTN_M_CD, 32'd1};
					end
					SL_SYNC: begin
						slot_ev.en = 1'b1;
						slot_ev.ev = '{EV_SYN, 16'd0, 32'd0};
					end
					default: slot_ev = '0;
				endcase
			end
			default: slot_ev = '0;
		endcase
	end

endmodule

// ----- tb/input_event_queue_to_guest_unit_test.sv -----
`timescale 1ns / 1ps

module input_event_queue_to_guest_unit_test;
	import iegu_pkg::*;

	localparam int RING_DEPTH   = 64;
	localparam int CREDIT_DEPTH = 256;
	localparam int MAX_RESULTS  = 6;
	localparam int RANDOM_ITEMS = 12;
	// hang guard; keep a wide margin over the worst run
	localparam int CYCLE_LIMIT  = 400000;
	// func codes the block leaves unused
	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;

	// one command item, as driven on the command side
	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] etype;
		logic [15:0] ecode;
		logic [31:0] evalue;
		logic        pressed;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [2:0]  buttons;
		logic        present;
		logic        writable;
		logic [31:0] blen;
	} cmd_t;

	// one result, as seen on the result side
	typedef struct packed {
		logic        delivered;
		event_t      ev;
		logic        interrupt;
		logic        accepted;
		logic [31:0] dropped;
		logic [31:0] sent;
		logic [6:0]  level;
		logic        last;
	} report_t;

	// Tracks ring, credits and counters and keeps the deliveries still owed by the block.
	class delivery_book;
		event_t      ring [RING_DEPTH];
		int unsigned head, tail, level, credits;
		logic [31:0] drops, sends;
		report_t     awaited [$];
		report_t     batch [$];
		int          errors, seen, handed;

		function new();
			head = 0;
			tail = 0;
			level = 0;
			credits = 0;
			drops = '0;
			sends = '0;
			errors = 0;
			seen = 0;
			handed = 0;
		endfunction

		// move events into held credits, one result each
		function void hand_over();
			report_t r;
			while (level > 0 && credits > 0 && batch.size() < MAX_RESULTS) begin
				r = '0;
				r.delivered = 1'b1;
				r.interrupt = 1'b1;
				r.ev = ring[head];
				head = (head + 1) % RING_DEPTH;
				level--;
				credits--;
				if (sends != '1)
					sends++;
				r.dropped = drops;
				r.sent = sends;
				r.level = level[6:0];
				batch.push_back(r);
			end
		endfunction

		function bit push_ev(logic [15:0] t, logic [15:0] c, logic [31:0] v);
			if (level >= RING_DEPTH) begin
				if (drops != '1)
					drops++;
				return 1'b0;
			end
			ring[tail] = '{ev_type: t, ev_code: c, ev_value: v};
			tail = (tail + 1) % RING_DEPTH;
			level++;
			hand_over();
			return 1'b1;
		endfunction

		// accepted item: work out the results it owes
		function void take_item(cmd_t c);
			bit ok, first_ok, sync_ok;
			report_t r;
			batch.delete();
			ok = 1'b0;
			case (c.func)
				FN_RAW: ok = push_ev(c.etype, c.ecode, c.evalue);
				FN_KEY: begin
					first_ok = push_ev(EV_KEY, c.ecode, {31'd0, c.pressed});
					sync_ok = push_ev(EV_SYN, 16'd0, 32'd0);
					ok = first_ok && sync_ok;
				end
				FN_MOUSE: begin
					if (c.dx != 0)
						void'(push_ev(EV_REL, REL_X, c.dx));
					if (c.dy != 0)
						void'(push_ev(EV_REL, REL_Y, c.dy));
					if ((c.buttons & BTN0_MASK) != 0)
						void'(push_ev(EV_KEY, BTN_L_CD, 32'd1));
					if ((c.buttons & BTN1_MASK) != 0)
						void'(push_ev(EV_KEY, BTN_R_CD, 32'd1));
					if ((c.buttons & BTN2_MASK) != 0)
						void'(push_ev(EV_KEY, BTN_M_CD, 32'd1));
					void'(push_ev(EV_SYN, 16'd0, 32'd0));
				end
				FN_BUF: begin
					if (c.present && c.writable && c.blen >= 32'd8
							&& credits < CREDIT_DEPTH) begin
						credits++;
						hand_over();
					end
				end
				FN_RESET: begin
					head = 0;
					tail = 0;
					level = 0;
					credits = 0;
				end
				default: ;
			endcase
			if (batch.size() == 0) begin
				r = '0;
				batch.push_back(r);
			end
			r = batch.pop_back();
			r.accepted = ok;
			r.dropped = drops;
			r.sent = sends;
			r.level = level[6:0];
			r.last = 1'b1;
			batch.push_back(r);
			foreach (batch[i])
				awaited.push_back(batch[i]);
		endfunction

		function void check_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void match_result(report_t got);
			report_t want;
			seen++;
			if (got.delivered === 1'b1)
				handed++;
			if (awaited.size() == 0) begin
				$error("result with no item waiting for it");
				errors++;
				return;
			end
			want = awaited.pop_front();
			check_field("delivered", want.delivered, got.delivered);
			check_field("out_type", want.ev.ev_type, got.ev.ev_type);
			check_field("out_code", want.ev.ev_code, got.ev.ev_code);
			check_field("out_value", want.ev.ev_value, got.ev.ev_value);
			check_field("interrupt", want.interrupt, got.interrupt);
			check_field("accepted", want.accepted, got.accepted);
			check_field("dropped_total", want.dropped, got.dropped);
			check_field("sent_total", want.sent, got.sent);
			check_field("queued_count", want.level, got.level);
			check_field("last", want.last, got.last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  func = FN_RAW;
	logic [15:0] event_type = '0;
	logic [15:0] event_code = '0;
	logic [31:0] event_value = '0;
	logic        pressed = 1'b0;
	logic signed [31:0] delta_x = '0;
	logic signed [31:0] delta_y = '0;
	logic [2:0]  buttons = '0;
	logic        buffer_present = 1'b0;
	logic        buffer_writable = 1'b0;
	logic [31:0] buffer_length = '0;
	logic        strobe;
	logic        delivered;
	logic [15:0] out_type;
	logic [15:0] out_code;
	logic [31:0] out_value;
	logic        interrupt;
	logic        accepted;
	logic [31:0] dropped_total;
	logic [31:0] sent_total;
	logic [6:0]  queued_count;
	logic        last;

	delivery_book book;
	int          cycle_count = 0;
	int          items_sent = 0;
	bit          no_gaps = 1'b0;

	input_event_queue_to_guest_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.event_type     (event_type),
		.event_code     (event_code),
		.event_value    (event_value),
		.pressed        (pressed),
		.delta_x        (delta_x),
		.delta_y        (delta_y),
		.buttons        (buttons),
		.buffer_present (buffer_present),
		.buffer_writable(buffer_writable),
		.buffer_length  (buffer_length),
		.strobe         (strobe),
		.delivered      (delivered),
		.out_type       (out_type),
		.out_code       (out_code),
		.out_value      (out_value),
		.interrupt      (interrupt),
		.accepted       (accepted),
		.dropped_total  (dropped_total),
		.sent_total     (sent_total),
		.queued_count   (queued_count),
		.last           (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Results cannot be held off: take every strobe at the edge that ends its cycle.
	always @(posedge clk) begin : result_watch
		report_t got;
		if (arst_n && strobe) begin
			got.delivered = delivered;
			got.ev = {out_type, out_code, out_value};
			got.interrupt = interrupt;
			got.accepted = accepted;
			got.dropped = dropped_total;
			got.sent = sent_total;
			got.level = queued_count;
			got.last = last;
			book.match_result(got);
		end
	end

	// Motion delta, weighted toward zero (axis skipped) and the signed extremes.
	function automatic logic [31:0] random_delta();
		case ($urandom_range(0, 7))
			0, 1: return 32'd0;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Every field gets random content; buf_pct sets the share of guest buffers.
	function automatic cmd_t random_cmd(input int buf_pct);
		cmd_t c;
		int   pick;
		c.etype = 16'($urandom);
		c.ecode = 16'($urandom);
		c.evalue = $urandom;
		c.pressed = 1'($urandom_range(0, 1));
		c.dx = random_delta();
		c.dy = random_delta();
		c.buttons = 3'($urandom_range(0, 7));
		c.present = ($urandom_range(0, 7) != 0);
		c.writable = ($urandom_range(0, 7) != 0);
		c.blen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 2)
			c.func = FN_RESET;
		else if (pick < 5)
			c.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
		else if (pick < 5 + buf_pct)
			c.func = FN_BUF;
		else
			case ($urandom_range(0, 2))
				0: c.func = FN_RAW;
				1: c.func = FN_KEY;
				default: c.func = FN_MOUSE;
			endcase
		return c;
	endfunction

	function automatic cmd_t usable_buffer();
		cmd_t c;
		c = random_cmd(0);
		c.func = FN_BUF;
		c.present = 1'b1;
		c.writable = 1'b1;
		c.blen = $urandom_range(32'hFFFF_FFFF, 8);
		return c;
	endfunction

	// Wait a random gap with start low, present the item, hold it until busy is low at an edge.
	// start is only lowered when a gap follows, so a back-to-back item keeps it high.
	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= c.func;
		event_type <= c.etype;
		event_code <= c.ecode;
		event_value <= c.evalue;
		pressed <= c.pressed;
		delta_x <= c.dx;
		delta_y <= c.dy;
		buttons <= c.buttons;
		buffer_present <= c.present;
		buffer_writable <= c.writable;
		buffer_length <= c.blen;
		do @(posedge clk); while (busy);
		book.take_item(c);
		items_sent++;
	endtask

	initial begin
		cmd_t c;
		int   random_items;
		int   seg_len;
		int   buf_pct;
		book = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// unused func on an empty block: single empty result
		c = random_cmd(0);
		c.func = FN_SPARE_LO;
		send_cmd(c);
		// raw events at both extremes, no credit yet so they stay queued
		c = random_cmd(0);
		c.func = FN_RAW;
		c.etype = '1;
		c.ecode = '1;
		c.evalue = '1;
		send_cmd(c);
		c.etype = '0;
		c.ecode = '0;
		c.evalue = '0;
		send_cmd(c);
		// key press on the top keycode, release on keycode zero
		c = random_cmd(0);
		c.func = FN_KEY;
		c.ecode = '1;
		c.pressed = 1'b1;
		send_cmd(c);
		c.ecode = '0;
		c.pressed = 1'b0;
		send_cmd(c);
		// mouse: sync only, then all six events, then X plus right button
		c = random_cmd(0);
		c.func = FN_MOUSE;
		c.dx = '0;
		c.dy = '0;
		c.buttons = '0;
		send_cmd(c);
		c.dx = 32'h8000_0000;
		c.dy = 32'h7FFF_FFFF;
		c.buttons = BTN0_MASK | BTN1_MASK | BTN2_MASK;
		send_cmd(c);
		c.dx = 32'hFFFF_FFFF;
		c.dy = '0;
		c.buttons = BTN1_MASK;
		send_cmd(c);
		// unusable buffers: absent, read-only, short, empty
		c = usable_buffer();
		c.present = 1'b0;
		c.blen = '1;
		send_cmd(c);
		c = usable_buffer();
		c.writable = 1'b0;
		c.blen = 32'd64;
		send_cmd(c);
		c = usable_buffer();
		c.blen = 32'd7;
		send_cmd(c);
		c.blen = 32'd0;
		send_cmd(c);
		// usable at exactly the minimum and at the top length, then a few more
		c.blen = 32'd8;
		send_cmd(c);
		c.blen = '1;
		send_cmd(c);
		repeat (4) send_cmd(usable_buffer());
		// full mouse items with no credits: the ring fills and the tail is dropped
		c = random_cmd(0);
		c.func = FN_MOUSE;
		c.dx = 32'd5;
		c.dy = 32'hFFFF_FFFB;
		c.buttons = BTN0_MASK | BTN1_MASK | BTN2_MASK;
		repeat (11) send_cmd(c);
		// reset with events still queued; counters must survive
		c = random_cmd(0);
		c.func = FN_RESET;
		send_cmd(c);
		// credits first, then a raw event goes straight out
		repeat (2) send_cmd(usable_buffer());
		c = random_cmd(0);
		c.func = FN_RAW;
		send_cmd(c);
		c.func = FN_SPARE_HI;
		send_cmd(c);
		c.func = FN_RESET;
		send_cmd(c);

		// --- random part ---
		// stretches of event-heavy, mixed and buffer-heavy traffic; the first one
		// has no buffers so events pile up early
		random_items = 0;
		buf_pct = 0;
		while (random_items < RANDOM_ITEMS) begin
			seg_len = $urandom_range(4, 12);
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (seg_len) begin
				c = random_cmd(buf_pct);
				send_cmd(c);
				if (c.func <= FN_RESET)
					random_items++;
			end
			case ($urandom_range(0, 3))
				0: buf_pct = 0;
				1: buf_pct = 25;
				2: buf_pct = 50;
				default: buf_pct = 80;
			endcase
		end

		// credit overflow: empty block, more usable buffers than it can hold,
		// then mouse items to draw the credits down again
		no_gaps = 1'b0;
		c = random_cmd(0);
		c.func = FN_RESET;
		send_cmd(c);
		repeat (CREDIT_DEPTH + 2) send_cmd(usable_buffer());
		repeat (4) begin
			c = random_cmd(0);
			c.func = FN_MOUSE;
			send_cmd(c);
		end
		start <= 1'b0;

		// drain, then wait on for stray results
		while (book.awaited.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (book.awaited.size() != 0) begin
			$error("%0d results never arrived", book.awaited.size());
			book.errors++;
		end

		$display("Run covered %0d items (%0d random), %0d results checked, %0d deliveries.",
			items_sent, random_items, book.seen, book.handed);
		$display("Events dropped on a full ring: %0d; mismatches: %0d.", book.drops,
			book.errors);
		if (book.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
